// ----- sv/alx_pkg.sv -----
// Shared types, character codes, token kinds and classification functions
// for the assembly source lexer. No dependencies.
package alx_pkg;

    // Token kinds
    localparam logic [5:0] KIND_EOF      = 6'd0;
    localparam logic [5:0] KIND_IDENT    = 6'd1;
    localparam logic [5:0] KIND_NUMBER   = 6'd2;
    localparam logic [5:0] KIND_COMMENT  = 6'd3;
    localparam logic [5:0] KIND_CHAR     = 6'd4;
    localparam logic [5:0] KIND_STRING   = 6'd5;
    localparam logic [5:0] KIND_COMMA    = 6'd6;
    localparam logic [5:0] KIND_DOT      = 6'd7;
    localparam logic [5:0] KIND_COLON    = 6'd8;
    localparam logic [5:0] KIND_LPAREN   = 6'd9;
    localparam logic [5:0] KIND_RPAREN   = 6'd10;
    localparam logic [5:0] KIND_LBRACKET = 6'd11;
    localparam logic [5:0] KIND_RBRACKET = 6'd12;
    localparam logic [5:0] KIND_LBRACE   = 6'd13;
    localparam logic [5:0] KIND_RBRACE   = 6'd14;
    localparam logic [5:0] KIND_PLUS     = 6'd15;
    localparam logic [5:0] KIND_MINUS    = 6'd16;
    localparam logic [5:0] KIND_STAR     = 6'd17;
    localparam logic [5:0] KIND_SLASH    = 6'd18;
    localparam logic [5:0] KIND_BANG     = 6'd19;
    localparam logic [5:0] KIND_AT       = 6'd20;
    localparam logic [5:0] KIND_HASH     = 6'd21;
    localparam logic [5:0] KIND_DOLLAR   = 6'd22;
    localparam logic [5:0] KIND_PERCENT  = 6'd23;
    localparam logic [5:0] KIND_CARET    = 6'd24;
    localparam logic [5:0] KIND_AMP      = 6'd25;
    localparam logic [5:0] KIND_QMARK    = 6'd26;
    localparam logic [5:0] KIND_TILDE    = 6'd27;
    localparam logic [5:0] KIND_LT       = 6'd28;
    localparam logic [5:0] KIND_GT       = 6'd29;
    localparam logic [5:0] KIND_LE       = 6'd30;
    localparam logic [5:0] KIND_GE       = 6'd31;
    localparam logic [5:0] KIND_ASSIGN   = 6'd32;
    localparam logic [5:0] KIND_NE       = 6'd33;
    localparam logic [5:0] KIND_ADD_EQ   = 6'd34;
    localparam logic [5:0] KIND_SUB_EQ   = 6'd35;
    localparam logic [5:0] KIND_MUL_EQ   = 6'd36;
    localparam logic [5:0] KIND_DIV_EQ   = 6'd37;

    // Error codes
    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN_CHAR = 2'd1;
    localparam logic [1:0] ERR_BAD_ESCAPE   = 2'd2;
    localparam logic [1:0] ERR_OPEN_CHAR    = 2'd3;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_XU     = 8'h58;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } t_req;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [31:0] number_value;
        logic [31:0] line_count;
        logic [7:0]  text_byte;
        logic [5:0]  text_index;
        logic        text_empty;
        logic        last_of_token;
        logic        text_truncated;
        logic        followed_by_colon;
        logic [1:0]  error_code;
    } t_res;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_ZERO, M_DEC, M_HEX, M_OP, M_COMMENT, M_STR,
        M_CHR_FIRST, M_CHR_ESC, M_CHR_CLOSE
    } t_mode;

    typedef enum logic [2:0] {
        S_WAIT, S_STEP, S_SCAN, S_PREP, S_EMIT, S_ONE, S_HALT
    } t_state;

    typedef enum logic [1:0] {ACC_KEEP, ACC_LOAD, ACC_DEC, ACC_HEX} t_acc_op;

    typedef struct packed {
        logic       latch;
        logic       app;
        logic       app_esc;
        t_acc_op    acc;
        logic       set_pend;
        logic       line_inc;
        logic       clr;
        logic       set_kind;
        logic [5:0] kind;
        logic       colon;
        logic       idx_clr;
        logic       out_text;
        logic       out_one;
        logic [1:0] err;
    } t_cmd;

    typedef struct packed {
        logic [7:0] ch;
        logic       eof;
        logic [7:0] pend;
        logic       len_zero;
        logic       last;
        logic       out_free;
    } t_stat;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_FF || b == CH_VT ||
               b == CH_LF || b == CH_CR;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd0;
        if (is_digit(b)) v = {1'b1, b[3:0]};
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            v = {1'b1, 4'(b[3:0] + 4'd9)};
        return v;
    endfunction

    // {valid, value}
    function automatic logic [8:0] esc_val(input logic [7:0] b);
        logic [8:0] v;
        case (b)
            8'h61:     v = {1'b1, 8'h07};   // a
            8'h62:     v = {1'b1, 8'h08};   // b
            8'h65:     v = {1'b1, 8'h1b};   // e
            8'h66:     v = {1'b1, 8'h0c};   // f
            8'h6E:     v = {1'b1, 8'h0a};   // n
            8'h72:     v = {1'b1, 8'h0d};   // r
            8'h74:     v = {1'b1, 8'h09};   // t
            8'h76:     v = {1'b1, 8'h0B};   // v
            CH_BSLASH: v = {1'b1, CH_BSLASH};
            CH_QUOTE:  v = {1'b1, CH_QUOTE};
            CH_DQUOTE: v = {1'b1, CH_DQUOTE};
            8'h3F:     v = {1'b1, 8'h3F};   // ?
            default:   v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] b);
        logic [5:0] k;
        case (b)
            8'h2C:   k = KIND_COMMA;
            8'h2E:   k = KIND_DOT;
            8'h3A:   k = KIND_COLON;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h5B:   k = KIND_LBRACKET;
            8'h5D:   k = KIND_RBRACKET;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            8'h21:   k = KIND_BANG;
            8'h40:   k = KIND_AT;
            8'h23:   k = KIND_HASH;
            8'h24:   k = KIND_DOLLAR;
            8'h25:   k = KIND_PERCENT;
            8'h5E:   k = KIND_CARET;
            8'h26:   k = KIND_AMP;
            8'h3F:   k = KIND_QMARK;
            8'h7E:   k = KIND_TILDE;
            8'h3C:   k = KIND_LT;
            8'h3E:   k = KIND_GT;
            8'h3D:   k = KIND_ASSIGN;
            default: k = KIND_EOF;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] double_kind(input logic [7:0] b);
        logic [5:0] k;
        case (b)
            8'h3C:   k = KIND_LE;
            8'h3E:   k = KIND_GE;
            8'h21:   k = KIND_NE;
            8'h2B:   k = KIND_ADD_EQ;
            8'h2D:   k = KIND_SUB_EQ;
            8'h2A:   k = KIND_MUL_EQ;
            8'h2F:   k = KIND_DIV_EQ;
            default: k = KIND_EOF;
        endcase
        return k;
    endfunction

endpackage

// ----- sv/alx_ctrl.sv -----
// Lexer controller: scan mode, escape flag and sequencing state machine.
// Depends on alx_pkg.
module alx_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  alx_pkg::t_stat i_stat,
    output alx_pkg::t_cmd  o_cmd
);
    import alx_pkg::*;

    t_state     r_state, n_state;
    t_state     r_after, n_after;
    t_mode      r_mode, n_mode;
    logic       r_esc, n_esc;
    logic [1:0] r_err, n_err;

    // step decode
    logic       d_app, d_app_esc, d_set_pend, d_line_inc, d_clr;
    logic       d_emit, d_colon, d_fail, d_eof_res, d_mode_we, d_esc_we, d_esc;
    t_acc_op    d_acc;
    logic [5:0] d_kind;
    logic [1:0] d_code;
    t_state     d_after;
    t_mode      d_mode;
    logic       do_scan, do_mode, do_eof;
    logic [7:0] b;
    logic [8:0] ev;
    logic [4:0] hv;

    assign b       = i_stat.ch;
    assign ev      = esc_val(b);
    assign hv      = hex_val(b);
    assign do_eof  = (r_state == S_STEP) && i_stat.eof;
    assign do_mode = (r_state == S_STEP) && !i_stat.eof && (r_mode != M_IDLE);
    assign do_scan = ((r_state == S_STEP) && !i_stat.eof && (r_mode == M_IDLE)) ||
                     (r_state == S_SCAN);

    always_comb begin
        d_app = 1'b0; d_app_esc = 1'b0; d_set_pend = 1'b0; d_line_inc = 1'b0;
        d_clr = 1'b0; d_emit = 1'b0; d_colon = 1'b0; d_fail = 1'b0;
        d_eof_res = 1'b0; d_mode_we = 1'b0; d_esc_we = 1'b0; d_esc = 1'b0;
        d_acc = ACC_KEEP; d_kind = KIND_EOF; d_code = ERR_NONE;
        d_after = S_WAIT; d_mode = M_IDLE;
        if (do_eof) begin
            d_after = S_ONE;
            case (r_mode)
                M_IDENT: begin d_emit = 1'b1; d_kind = KIND_IDENT; end
                M_ZERO, M_DEC, M_HEX: begin d_emit = 1'b1; d_kind = KIND_NUMBER; end
                M_OP: begin d_emit = 1'b1; d_kind = single_kind(i_stat.pend); end
                M_COMMENT: begin d_emit = 1'b1; d_kind = KIND_COMMENT; end
                M_STR: begin
                    if (r_esc) begin d_fail = 1'b1; d_code = ERR_BAD_ESCAPE; end
                    else begin d_emit = 1'b1; d_kind = KIND_STRING; end
                end
                M_CHR_ESC: begin d_fail = 1'b1; d_code = ERR_BAD_ESCAPE; end
                M_CHR_FIRST, M_CHR_CLOSE: begin d_fail = 1'b1; d_code = ERR_OPEN_CHAR; end
                default: begin d_eof_res = 1'b1; d_clr = 1'b1; end
            endcase
        end else if (do_mode) begin
            case (r_mode)
                M_IDENT: begin
                    if (is_alpha(b) || is_digit(b)) d_app = 1'b1;
                    else if (b == CH_COLON) begin
                        d_emit = 1'b1; d_kind = KIND_IDENT; d_colon = 1'b1;
                    end else begin
                        d_emit = 1'b1; d_kind = KIND_IDENT; d_after = S_SCAN;
                    end
                end
                M_ZERO: begin
                    if (b == CH_X || b == CH_XU) begin
                        d_app = 1'b1; d_mode_we = 1'b1; d_mode = M_HEX;
                    end else if (is_digit(b)) begin
                        d_app = 1'b1; d_acc = ACC_LOAD; d_mode_we = 1'b1; d_mode = M_DEC;
                    end else begin
                        d_emit = 1'b1; d_kind = KIND_NUMBER; d_after = S_SCAN;
                    end
                end
                M_DEC: begin
                    if (is_digit(b)) begin d_app = 1'b1; d_acc = ACC_DEC; end
                    else begin d_emit = 1'b1; d_kind = KIND_NUMBER; d_after = S_SCAN; end
                end
                M_HEX: begin
                    if (hv[4]) begin d_app = 1'b1; d_acc = ACC_HEX; end
                    else begin d_emit = 1'b1; d_kind = KIND_NUMBER; d_after = S_SCAN; end
                end
                M_OP: begin
                    if (b == CH_EQ) begin
                        d_app = 1'b1; d_emit = 1'b1; d_kind = double_kind(i_stat.pend);
                    end else begin
                        d_emit = 1'b1; d_kind = single_kind(i_stat.pend); d_after = S_SCAN;
                    end
                end
                M_COMMENT: begin
                    if (b == CH_LF) begin
                        d_emit = 1'b1; d_kind = KIND_COMMENT; d_after = S_SCAN;
                    end else d_app = 1'b1;
                end
                M_STR: begin
                    if (r_esc) begin
                        if (ev[8]) begin
                            d_app = 1'b1; d_app_esc = 1'b1; d_esc_we = 1'b1;
                        end else begin d_fail = 1'b1; d_code = ERR_BAD_ESCAPE; end
                    end else if (b == CH_DQUOTE) begin
                        d_emit = 1'b1; d_kind = KIND_STRING;
                    end else if (b == CH_BSLASH) begin
                        d_esc_we = 1'b1; d_esc = 1'b1;
                    end else d_app = 1'b1;
                end
                M_CHR_FIRST: begin
                    d_mode_we = 1'b1;
                    if (b == CH_BSLASH) d_mode = M_CHR_ESC;
                    else begin d_app = 1'b1; d_mode = M_CHR_CLOSE; end
                end
                M_CHR_ESC: begin
                    if (ev[8]) begin
                        d_app = 1'b1; d_app_esc = 1'b1; d_mode_we = 1'b1; d_mode = M_CHR_CLOSE;
                    end else begin d_fail = 1'b1; d_code = ERR_BAD_ESCAPE; end
                end
                M_CHR_CLOSE: begin
                    if (b == CH_QUOTE) begin d_emit = 1'b1; d_kind = KIND_CHAR; end
                    else begin d_fail = 1'b1; d_code = ERR_OPEN_CHAR; end
                end
                default: ;
            endcase
        end else if (do_scan) begin
            if (is_ws(b)) begin
                d_line_inc = (b == CH_LF) || (b == CH_CR);
            end else begin
                d_clr = 1'b1;
                d_mode_we = 1'b1;
                if (b == CH_SEMI) begin d_mode = M_COMMENT; d_app = 1'b1; end
                else if (is_alpha(b)) begin d_mode = M_IDENT; d_app = 1'b1; end
                else if (is_digit(b)) begin
                    d_mode = (b == CH_ZERO) ? M_ZERO : M_DEC;
                    d_acc = ACC_LOAD; d_app = 1'b1;
                end else if (b == CH_QUOTE) d_mode = M_CHR_FIRST;
                else if (b == CH_DQUOTE) d_mode = M_STR;
                else if (double_kind(b) != KIND_EOF) begin
                    d_mode = M_OP; d_set_pend = 1'b1; d_app = 1'b1;
                end else if (single_kind(b) != KIND_EOF) begin
                    d_app = 1'b1; d_emit = 1'b1; d_kind = single_kind(b);
                end else begin d_fail = 1'b1; d_code = ERR_UNKNOWN_CHAR; end
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state; n_after = r_after; n_mode = r_mode;
        n_esc = r_esc; n_err = r_err;
        case (r_state)
            S_WAIT: if (i_valid) n_state = S_STEP;
            S_STEP, S_SCAN: begin
                if (d_mode_we) n_mode = d_mode;
                if (d_esc_we) n_esc = d_esc;
                if (d_fail) begin
                    n_state = S_ONE; n_err = d_code; n_mode = M_IDLE; n_esc = 1'b0;
                end else if (d_emit) begin
                    n_state = S_PREP; n_after = d_after; n_err = ERR_NONE;
                end else if (d_eof_res) begin
                    n_state = S_ONE; n_err = ERR_NONE; n_mode = M_IDLE; n_esc = 1'b0;
                end else n_state = S_WAIT;
            end
            S_PREP: n_state = S_EMIT;
            S_EMIT: begin
                if (i_stat.out_free && (i_stat.len_zero || i_stat.last)) begin
                    n_state = r_after; n_mode = M_IDLE; n_esc = 1'b0;
                end
            end
            S_ONE: if (i_stat.out_free) n_state = (r_err != ERR_NONE) ? S_HALT : S_WAIT;
            S_HALT: n_state = S_HALT;
            default: n_state = S_WAIT;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_cmd.acc  = ACC_KEEP;
        o_cmd.err  = r_err;
        o_cmd.kind = d_kind;
        o_cmd.colon = d_colon;
        o_ready = (r_state == S_WAIT) || (r_state == S_HALT);
        case (r_state)
            S_WAIT: o_cmd.latch = i_valid;
            S_STEP, S_SCAN: begin
                o_cmd.app      = d_app;
                o_cmd.app_esc  = d_app_esc;
                o_cmd.acc      = d_acc;
                o_cmd.set_pend = d_set_pend;
                o_cmd.line_inc = d_line_inc;
                o_cmd.clr      = d_clr || d_fail;
                o_cmd.set_kind = d_emit;
            end
            S_PREP: o_cmd.idx_clr = 1'b1;
            S_EMIT: begin
                o_cmd.out_text = i_stat.out_free;
                o_cmd.clr = i_stat.out_free && (i_stat.len_zero || i_stat.last);
            end
            S_ONE: o_cmd.out_one = i_stat.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
            r_after <= S_WAIT;
            r_mode  <= M_IDLE;
            r_esc   <= 1'b0;
            r_err   <= ERR_NONE;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_mode  <= n_mode;
            r_esc   <= n_esc;
            r_err   <= n_err;
        end
    end

endmodule

// ----- sv/alx_dp.sv -----
// Lexer datapath: request latch, token text memory, number accumulator,
// line counter and the result output register. Depends on alx_pkg.
module alx_dp #(
    parameter int TEXT_BYTES = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  alx_pkg::t_req  i_req,
    input  alx_pkg::t_cmd  i_cmd,
    input  logic           i_ready,
    output alx_pkg::t_stat o_stat,
    output logic           o_valid,
    output alx_pkg::t_res  o_res
);
    import alx_pkg::*;

    localparam int AW = $clog2(TEXT_BYTES);

    logic [7:0]    r_mem [TEXT_BYTES];
    logic [7:0]    r_rdata;
    logic [7:0]    r_ch;
    logic          r_eof;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_len, n_len, base;
    logic          r_trunc, n_trunc;
    logic [31:0]   r_acc, n_acc;
    logic [31:0]   r_lines;
    logic [7:0]    r_pend, n_pend;
    logic [5:0]    r_kind;
    logic          r_colon;
    logic          r_ovalid;
    t_res          r_res;
    logic          wr_en;
    logic [7:0]    wr_data;
    logic [AW-1:0] idx_next;
    logic [8:0]    ch_esc;
    logic [4:0]    ch_hex;

    assign idx_next = AW'(r_idx + AW'(1));
    assign ch_esc   = esc_val(r_ch);
    assign ch_hex   = hex_val(r_ch);

    always_comb begin
        base    = i_cmd.clr ? '0 : r_len;
        n_len   = base;
        n_trunc = i_cmd.clr ? 1'b0 : r_trunc;
        wr_en   = 1'b0;
        wr_data = i_cmd.app_esc ? ch_esc[7:0] : r_ch;
        if (i_cmd.app) begin
            if (base < AW'(TEXT_BYTES - 1)) begin
                wr_en = 1'b1;
                n_len = AW'(base + AW'(1));
            end else n_trunc = 1'b1;
        end
        case (i_cmd.acc)
            ACC_LOAD: n_acc = {28'd0, r_ch[3:0]};
            ACC_DEC:  n_acc = (r_acc << 3) + (r_acc << 1) + {28'd0, r_ch[3:0]};
            ACC_HEX:  n_acc = (r_acc << 4) + {28'd0, ch_hex[3:0]};
            default:  n_acc = i_cmd.clr ? 32'd0 : r_acc;
        endcase
        n_pend = i_cmd.set_pend ? r_ch : (i_cmd.clr ? 8'd0 : r_pend);
        if (i_cmd.idx_clr) n_idx = '0;
        else if (i_cmd.out_text) n_idx = idx_next;
        else n_idx = r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[base] <= wr_data;
        r_rdata <= r_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.latch) begin
            r_ch  <= i_req.char_byte;
            r_eof <= i_req.end_of_input;
        end
        if (i_cmd.set_kind) begin
            r_kind  <= i_cmd.kind;
            r_colon <= i_cmd.colon;
        end
        if (i_cmd.out_text) begin
            r_res.token_kind        <= r_kind;
            r_res.number_value      <= (r_kind == KIND_NUMBER) ? r_acc : 32'd0;
            r_res.line_count        <= r_lines;
            r_res.text_byte         <= (r_len == '0) ? 8'd0 : r_rdata;
            r_res.text_index        <= (r_len == '0) ? 6'd0 : 6'(r_idx);
            r_res.text_empty        <= (r_len == '0);
            r_res.last_of_token     <= (r_len == '0) || (idx_next == r_len);
            r_res.text_truncated    <= r_trunc;
            r_res.followed_by_colon <= r_colon;
            r_res.error_code        <= ERR_NONE;
        end else if (i_cmd.out_one) begin
            r_res.token_kind        <= KIND_EOF;
            r_res.number_value      <= 32'd0;
            r_res.line_count        <= r_lines;
            r_res.text_byte         <= 8'd0;
            r_res.text_index        <= 6'd0;
            r_res.text_empty        <= 1'b1;
            r_res.last_of_token     <= 1'b1;
            r_res.text_truncated    <= 1'b0;
            r_res.followed_by_colon <= 1'b0;
            r_res.error_code        <= i_cmd.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_trunc  <= 1'b0;
            r_acc    <= 32'd0;
            r_lines  <= 32'd0;
            r_pend   <= 8'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_len   <= n_len;
            r_trunc <= n_trunc;
            r_acc   <= n_acc;
            r_pend  <= n_pend;
            if (i_cmd.line_inc) r_lines <= r_lines + 32'd1;
            if (i_cmd.out_text || i_cmd.out_one) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    assign o_stat.ch       = r_ch;
    assign o_stat.eof      = r_eof;
    assign o_stat.pend     = r_pend;
    assign o_stat.len_zero = (r_len == '0);
    assign o_stat.last     = (idx_next == r_len);
    assign o_stat.out_free = !r_ovalid || i_ready;
    assign o_valid         = r_ovalid;
    assign o_res           = r_res;

endmodule

// ----- sv/assembly_source_lexer.sv -----
// Assembly source lexer: top level joining the controller and the datapath.
// Depends on alx_pkg, alx_ctrl and alx_dp.
//
// Takes one source byte (or an end mark) per request and returns tokens as a
// stream of results, one per text byte with the last one marked. A byte that
// extends or starts a token without finishing one is accepted, then stepped.
// Finishing a token passes a setup state, then emits one text byte per cycle
// while the output register is free, set by the single read port of the text
// memory (TEXT_BYTES entries, TEXT_BYTES-1 bytes kept); a byte that both ends
// one token and starts the next is rescanned after the token is out. Error
// and end results are emitted as a single result. Output stalls hold the
// emission until the output register is free. A result waits in an output
// register, so the next request is taken while it is still pending. After an
// error result the block swallows every request and stays silent until reset.
module assembly_source_lexer #(
    parameter int TEXT_BYTES = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  alx_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output alx_pkg::t_res o_res
);
    import alx_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequence each request: step, rescan, emit
    alx_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // hold text, value and line count; drive the result register
    alx_dp #(
        .TEXT_BYTES (TEXT_BYTES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .i_ready (i_ready),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    // load a result only when the output register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_text || cmd.out_one) |-> stat.out_free)
        else $error("result loaded over a pending result");

    // an error result carries no text and closes its token
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.error_code != ERR_NONE) |->
        (o_res.text_empty && o_res.last_of_token))
        else $error("error result with text");

    // append text only while a request is in work
    a_app_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.app |-> !o_ready)
        else $error("text appended while accepting");
`endif

endmodule

// ----- sim/alx_token_checker.sv -----
// Token checker for the assembly source lexer: tracks the scanner state from
// accepted requests, predicts every token result and compares. Needs alx_pkg.
module alx_token_checker
    import alx_pkg::*;
#(
    parameter int TEXT_BYTES = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_ready,
    input  t_req i_req,
    input  logic i_res_valid,
    input  logic i_res_ready,
    input  t_res i_res,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int KEEP = TEXT_BYTES - 1;
    localparam string OPS_ONE = ",.:()[]{}+-*/!@#$%^&?~<>";
    localparam string OPS_TWO = "<>!+-*/";

    t_res        expected_tokens[$];
    t_mode       mode;
    logic [7:0]  tok_text[TEXT_BYTES];
    int          tok_len;
    logic        tok_trunc;
    logic [31:0] num_acc;
    logic [31:0] nl_total;
    logic [7:0]  op_char;
    logic        esc_wait;
    logic        halted;

    function automatic void add_res(logic [5:0] k, logic [31:0] v, logic [7:0] b,
                                    logic [5:0] ix, logic e, logic l, logic t,
                                    logic c, logic [1:0] er);
        t_res r;
        r.token_kind = k;        r.number_value = v;   r.line_count = nl_total;
        r.text_byte = b;         r.text_index = ix;    r.text_empty = e;
        r.last_of_token = l;     r.text_truncated = t; r.followed_by_colon = c;
        r.error_code = er;
        expected_tokens.push_back(r);
    endfunction

    function automatic void clear_tok();
        tok_len = 0; tok_trunc = 1'b0; num_acc = '0;
        esc_wait = 1'b0; op_char = '0; mode = M_IDLE;
    endfunction

    function automatic void keep(logic [7:0] b);
        if (tok_len < KEEP) begin
            tok_text[tok_len] = b;
            tok_len++;
        end else begin
            tok_trunc = 1'b1;
        end
    endfunction

    function automatic void flush_tok(logic [5:0] k, logic c);
        logic [31:0] v;
        v = (k == KIND_NUMBER) ? num_acc : '0;
        if (tok_len == 0) begin
            add_res(k, v, '0, '0, 1'b1, 1'b1, tok_trunc, c, ERR_NONE);
        end else begin
            for (int i = 0; i < tok_len; i++)
                add_res(k, v, tok_text[i], 6'(i), 1'b0, i + 1 == tok_len, tok_trunc, c,
                        ERR_NONE);
        end
        clear_tok();
    endfunction

    function automatic void abort(logic [1:0] code);
        add_res(KIND_EOF, '0, '0, '0, 1'b1, 1'b1, 1'b0, 1'b0, code);
        clear_tok();
        halted = 1'b1;
    endfunction

    function automatic logic is_letter(logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_";
    endfunction

    function automatic logic is_num(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    // {ok, nibble}
    function automatic logic [4:0] hex_digit(logic [7:0] b);
        if (is_num(b)) return {1'b1, 4'(b - "0")};
        if (b >= "a" && b <= "f") return {1'b1, 4'(b - "a" + 10)};
        if (b >= "A" && b <= "F") return {1'b1, 4'(b - "A" + 10)};
        return '0;
    endfunction

    // {ok, resolved byte}
    function automatic logic [8:0] unescape(logic [7:0] b);
        case (b)
            "a": return {1'b1, 8'h07};
            "b": return {1'b1, 8'h08};
            "e": return {1'b1, 8'h1b};
            "f": return {1'b1, CH_FF};
            "n": return {1'b1, CH_LF};
            "r": return {1'b1, CH_CR};
            "t": return {1'b1, CH_TAB};
            "v": return {1'b1, CH_VT};
            CH_BSLASH, CH_QUOTE, CH_DQUOTE, "?": return {1'b1, b};
            default: return '0;
        endcase
    endfunction

    function automatic logic [5:0] one_op(logic [7:0] b);
        if (b == CH_EQ) return KIND_ASSIGN;
        for (int i = 0; i < OPS_ONE.len(); i++)
            if (OPS_ONE[i] == b) return KIND_COMMA + 6'(i);
        return KIND_EOF;
    endfunction

    function automatic logic [5:0] two_op(logic [7:0] b);
        for (int i = 0; i < OPS_TWO.len(); i++)
            if (OPS_TWO[i] == b) return (i < 2) ? KIND_LE + 6'(i) : KIND_NE + 6'(i - 2);
        return KIND_EOF;
    endfunction

    // Returns 1 if the byte ended a token without being taken, or if idle.
    function automatic logic scan_in_mode(logic [7:0] b);
        logic [8:0] esc;
        logic [4:0] hx;
        esc = unescape(b);
        hx  = hex_digit(b);
        case (mode)
            M_IDENT: begin
                if (is_letter(b) || is_num(b)) begin keep(b); return 1'b0; end
                if (b == CH_COLON) begin flush_tok(KIND_IDENT, 1'b1); return 1'b0; end
                flush_tok(KIND_IDENT, 1'b0);
                return 1'b1;
            end
            M_ZERO: begin
                if (b == CH_X || b == CH_XU) begin keep(b); mode = M_HEX; return 1'b0; end
                if (is_num(b)) begin
                    keep(b); num_acc = 32'(b - "0"); mode = M_DEC;
                    return 1'b0;
                end
                flush_tok(KIND_NUMBER, 1'b0);
                return 1'b1;
            end
            M_DEC: begin
                if (is_num(b)) begin keep(b); num_acc = num_acc * 10 + 32'(b - "0"); return 1'b0; end
                flush_tok(KIND_NUMBER, 1'b0);
                return 1'b1;
            end
            M_HEX: begin
                if (hx[4]) begin keep(b); num_acc = (num_acc << 4) + 32'(hx[3:0]); return 1'b0; end
                flush_tok(KIND_NUMBER, 1'b0);
                return 1'b1;
            end
            M_OP: begin
                if (b == CH_EQ) begin keep(b); flush_tok(two_op(op_char), 1'b0); return 1'b0; end
                flush_tok(one_op(op_char), 1'b0);
                return 1'b1;
            end
            M_COMMENT: begin
                if (b == CH_LF) begin flush_tok(KIND_COMMENT, 1'b0); return 1'b1; end
                keep(b);
                return 1'b0;
            end
            M_STR: begin
                if (esc_wait) begin
                    if (!esc[8]) abort(ERR_BAD_ESCAPE);
                    else begin keep(esc[7:0]); esc_wait = 1'b0; end
                end else if (b == CH_DQUOTE) flush_tok(KIND_STRING, 1'b0);
                else if (b == CH_BSLASH) esc_wait = 1'b1;
                else keep(b);
                return 1'b0;
            end
            M_CHR_FIRST: begin
                if (b == CH_BSLASH) mode = M_CHR_ESC;
                else begin keep(b); mode = M_CHR_CLOSE; end
                return 1'b0;
            end
            M_CHR_ESC: begin
                if (!esc[8]) abort(ERR_BAD_ESCAPE);
                else begin keep(esc[7:0]); mode = M_CHR_CLOSE; end
                return 1'b0;
            end
            M_CHR_CLOSE: begin
                if (b == CH_QUOTE) flush_tok(KIND_CHAR, 1'b0);
                else abort(ERR_OPEN_CHAR);
                return 1'b0;
            end
            default: return 1'b1;
        endcase
    endfunction

    function automatic void scan_idle(logic [7:0] b);
        if (b == CH_SPACE || b == CH_TAB || b == CH_FF || b == CH_VT ||
            b == CH_LF || b == CH_CR) begin
            if (b == CH_LF || b == CH_CR) nl_total++;
            return;
        end
        clear_tok();
        if (b == CH_SEMI) begin mode = M_COMMENT; keep(b); end
        else if (is_letter(b)) begin mode = M_IDENT; keep(b); end
        else if (is_num(b)) begin
            mode = (b == CH_ZERO) ? M_ZERO : M_DEC;
            num_acc = 32'(b - "0");
            keep(b);
        end
        else if (b == CH_QUOTE) mode = M_CHR_FIRST;
        else if (b == CH_DQUOTE) mode = M_STR;
        else if (two_op(b) != KIND_EOF) begin mode = M_OP; op_char = b; keep(b); end
        else if (one_op(b) != KIND_EOF) begin keep(b); flush_tok(one_op(b), 1'b0); end
        else abort(ERR_UNKNOWN_CHAR);
    endfunction

    function automatic void finish_source();
        case (mode)
            M_IDENT: flush_tok(KIND_IDENT, 1'b0);
            M_ZERO, M_DEC, M_HEX: flush_tok(KIND_NUMBER, 1'b0);
            M_OP: flush_tok(one_op(op_char), 1'b0);
            M_COMMENT: flush_tok(KIND_COMMENT, 1'b0);
            M_STR: begin
                if (esc_wait) begin abort(ERR_BAD_ESCAPE); return; end
                flush_tok(KIND_STRING, 1'b0);
            end
            M_CHR_ESC: begin abort(ERR_BAD_ESCAPE); return; end
            M_CHR_FIRST, M_CHR_CLOSE: begin abort(ERR_OPEN_CHAR); return; end
            default: ;
        endcase
        clear_tok();
        add_res(KIND_EOF, '0, '0, '0, 1'b1, 1'b1, 1'b0, 1'b0, ERR_NONE);
    endfunction

    function automatic void predict_tokens(t_req r);
        if (halted) return;
        if (r.end_of_input) finish_source();
        else if (scan_in_mode(r.char_byte) && !halted) scan_idle(r.char_byte);
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            expected_tokens.delete();
            clear_tok();
            nl_total = '0;
            halted = 1'b0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_tokens.size() == 0) begin
                    report("unexpected result, kind", i_res.token_kind, '0);
                end else begin
                    want = expected_tokens.pop_front();
                    if (i_res.token_kind !== want.token_kind)
                        report("token_kind", i_res.token_kind, want.token_kind);
                    if (i_res.number_value !== want.number_value)
                        report("number_value", i_res.number_value, want.number_value);
                    if (i_res.line_count !== want.line_count)
                        report("line_count", i_res.line_count, want.line_count);
                    if (i_res.text_byte !== want.text_byte)
                        report("text_byte", i_res.text_byte, want.text_byte);
                    if (i_res.text_index !== want.text_index)
                        report("text_index", i_res.text_index, want.text_index);
                    if (i_res.text_empty !== want.text_empty)
                        report("text_empty", i_res.text_empty, want.text_empty);
                    if (i_res.last_of_token !== want.last_of_token)
                        report("last_of_token", i_res.last_of_token, want.last_of_token);
                    if (i_res.text_truncated !== want.text_truncated)
                        report("text_truncated", i_res.text_truncated, want.text_truncated);
                    if (i_res.followed_by_colon !== want.followed_by_colon)
                        report("followed_by_colon", i_res.followed_by_colon,
                               want.followed_by_colon);
                    if (i_res.error_code !== want.error_code)
                        report("error_code", i_res.error_code, want.error_code);
                end
            end
            if (i_req_valid && i_req_ready) predict_tokens(i_req);
        end
        o_pending = expected_tokens.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

endmodule

// ----- sim/assembly_source_lexer_tb.sv -----
// Testbench top for the assembly source lexer: builds source text, drives
// requests, stalls the result side and gives the verdict. Needs alx_pkg,
// alx_token_checker and the lexer RTL.
module assembly_source_lexer_tb;
    import alx_pkg::*;

    localparam int RANDOM_BYTES = 80;
    localparam int IDLE_LIMIT   = 6000;
    localparam int DRAIN_CYCLES = 80;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_req i_req;
    logic o_valid;
    logic i_ready;
    t_res o_res;

    int fail_count;
    int pending;
    int send_idle_pct;   // chance in percent that the sender skips a cycle
    int recv_stall_pct;  // chance in percent that the receiver stalls a cycle
    int hold_cycles;     // long receiver hold-off, counted down by the receiver
    int quiet_cycles;
    t_req source_bytes[$];

    assembly_source_lexer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

    alx_token_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_req        (i_req),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Result side: honor a pending hold-off first, else stall at random.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_ready = 1'b0;
                hold_cycles--;
            end else begin
                i_ready = ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: abort when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Queue one source byte or an end mark.
    function automatic void put_byte(logic [7:0] b);
        t_req r;
        r.char_byte = b;
        r.end_of_input = 1'b0;
        source_bytes.push_back(r);
    endfunction

    function automatic void put_end();
        t_req r;
        r.char_byte = 8'($urandom_range(0, 255));
        r.end_of_input = 1'b1;
        source_bytes.push_back(r);
    endfunction

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // Whitespace byte from the first n of: space, tab, LF, FF, VT, CR.
    function automatic logic [7:0] pick_space(int n);
        logic [7:0] v;
        case ($urandom_range(0, n - 1))
            0: v = CH_SPACE;
            1: v = CH_TAB;
            2: v = CH_LF;
            3: v = CH_FF;
            4: v = CH_VT;
            default: v = CH_CR;
        endcase
        return v;
    endfunction

    // Any byte except the ones listed; keeps literals and comments closed.
    function automatic logic [7:0] any_byte_but(logic [7:0] a, logic [7:0] b);
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        while (v == a || v == b) v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    // Append one well-formed token, separator or end mark with random content.
    function automatic void add_random_token();
        string alnum;
        string escs;
        int n;
        alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        escs  = "abefnrtv\\'\"?";
        case ($urandom_range(0, 9))
            0: begin
                n = ($urandom_range(0, 9) == 0) ? 35 : $urandom_range(1, 6);
                put_byte(alnum[$urandom_range(0, 52)]);
                repeat (n - 1) put_byte(pick(alnum));
                if ($urandom_range(0, 2) == 0) put_byte(CH_COLON);
            end
            1: repeat ($urandom_range(1, 12)) put_byte(pick("0123456789"));
            2: begin
                put_byte(CH_ZERO);
                put_byte($urandom_range(0, 1) ? CH_X : CH_XU);
                repeat ($urandom_range(0, 10)) put_byte(pick("0123456789abcdefABCDEF"));
            end
            3: begin
                put_byte(CH_SEMI);
                repeat ($urandom_range(0, 8)) put_byte(any_byte_but(CH_LF, CH_LF));
                put_byte(CH_LF);
            end
            4: begin
                put_byte(CH_DQUOTE);
                n = ($urandom_range(0, 9) == 0) ? 36 : $urandom_range(0, 5);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) begin
                        put_byte(CH_BSLASH);
                        put_byte(pick(escs));
                    end else begin
                        put_byte(any_byte_but(CH_DQUOTE, CH_BSLASH));
                    end
                end
                put_byte(CH_DQUOTE);
            end
            5: begin
                put_byte(CH_QUOTE);
                if ($urandom_range(0, 2) == 0) begin
                    put_byte(CH_BSLASH);
                    put_byte(pick(escs));
                end else begin
                    put_byte(any_byte_but(CH_BSLASH, CH_BSLASH));
                end
                put_byte(CH_QUOTE);
            end
            6: put_byte(pick(",.:()[]{}+-*/!@#$%^&?~<>="));
            7: begin
                put_byte(pick("<>!+-*/"));
                put_byte(CH_EQ);
            end
            8: repeat ($urandom_range(1, 3)) put_byte(pick_space(6));
            default: put_end();
        endcase
        if ($urandom_range(0, 9) < 6) put_byte(pick_space(3));
    endfunction

    // Offer one request and hold it until the block takes it.
    task automatic send_request(t_req r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_req = r;
        while (!o_ready) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_source();
        while (source_bytes.size() > 0) send_request(source_bytes.pop_front());
    endtask

    initial begin
        int sent;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: colon label, hex, escaped char, string escape, comment
        // holding CR and a high byte, end mark, then a string and a bare 0x cut by the end.
        put_byte("l"); put_byte("b"); put_byte(CH_COLON); put_byte(CH_ZERO);
        put_byte(CH_X); put_byte("F"); put_byte(CH_SPACE);
        put_byte(CH_QUOTE); put_byte(CH_BSLASH); put_byte("n"); put_byte(CH_QUOTE);
        put_byte(CH_DQUOTE); put_byte(CH_BSLASH); put_byte("t"); put_byte(CH_DQUOTE);
        put_byte(CH_SEMI); put_byte(8'hFF); put_byte(CH_CR); put_byte(CH_LF);
        put_end();
        put_byte(CH_DQUOTE); put_byte("a"); put_end();
        put_byte(CH_ZERO); put_byte(CH_X); put_end();
        drain_source();

        // Random: pressure first, then the idling phases in turn.
        hold_cycles = 250;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            case (sent * 4 / RANDOM_BYTES)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            add_random_token();
            sent += source_bytes.size();
            drain_source();
        end

        // Close with a bad string escape; the bytes after it must stay silent.
        put_end();
        put_byte(CH_DQUOTE); put_byte(CH_BSLASH); put_byte("q");
        put_byte("a"); put_end();
        drain_source();
        i_valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/alx_pkg.sv
sv/alx_ctrl.sv
sv/alx_dp.sv
sv/assembly_source_lexer.sv
sim/alx_token_checker.sv
sim/assembly_source_lexer_tb.sv
